// ===== hw/rtl/nlip_pkg.sv =====
package nlip_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned WordW   = 16;
    localparam int unsigned SkipW   = 6;
    localparam int unsigned QDepth  = 4;

    localparam logic [SkipW-1:0] SkipReset = 6'd35;

    localparam logic [WordW-1:0] ZoneMark = 16'hFFFF;
    localparam logic [WordW-1:0] HostMark = 16'hFFFE;
    localparam logic [WordW-1:0] EndWord  = 16'h0000;

    localparam logic [ByteW-1:0] ChNul   = 8'd0;
    localparam logic [ByteW-1:0] ChLf    = 8'd10;
    localparam logic [ByteW-1:0] ChCr    = 8'd13;
    localparam logic [ByteW-1:0] ChEof   = 8'd26;
    localparam logic [ByteW-1:0] ChEsc   = 8'd27;
    localparam logic [ByteW-1:0] ChComma = 8'd44;
    localparam logic [ByteW-1:0] ChSemi  = 8'd59;
    localparam logic [ByteW-1:0] ChZero  = 8'd48;
    localparam logic [ByteW-1:0] ChD     = 8'd68;
    localparam logic [ByteW-1:0] ChH     = 8'd72;
    localparam logic [ByteW-1:0] ChP     = 8'd80;
    localparam logic [ByteW-1:0] ChR     = 8'd82;
    localparam logic [ByteW-1:0] ChZ     = 8'd90;
    localparam logic [ByteW-1:0] ChLowL  = 8'd108;
    localparam logic [ByteW-1:0] ChLowU  = 8'd117;

    typedef enum logic [5:0] {
        PH_LINE    = 6'b000001,
        PH_COMMENT = 6'b000010,
        PH_FIELDS  = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_TAIL    = 6'b010000,
        PH_HALT    = 6'b100000
    } phase_t;

    // words produced by one accepted byte, oldest first
    typedef struct packed {
        logic [1:0]       count;
        logic [WordW-1:0] word0;
        logic [WordW-1:0] word1;
    } push_t;

endpackage

// ===== hw/rtl/nlip_parser.sv =====
module nlip_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [nlip_pkg::SkipW-1:0]       cfg_wr_data,
    input  logic                             byte_fire,
    input  logic [nlip_pkg::ByteW-1:0]       byte_in,
    output nlip_pkg::push_t                  push
);

    nlip_pkg::phase_t              phase_reg, phase_next;
    logic [nlip_pkg::ByteW-1:0]    head0_reg, head0_next;
    logic [nlip_pkg::ByteW-1:0]    head1_reg, head1_next;
    logic [nlip_pkg::ByteW-1:0]    head2_reg, head2_next;
    logic [1:0]                    chars_reg, chars_next;
    logic [1:0]                    commas_reg, commas_next;
    logic [nlip_pkg::WordW-1:0]    acc_reg, acc_next;
    logic [nlip_pkg::SkipW-1:0]    skip_reg, skip_next;
    logic [nlip_pkg::SkipW-1:0]    cfg_skip_reg;

    logic                          in_number;
    logic [nlip_pkg::WordW-1:0]    num;
    logic [nlip_pkg::WordW-1:0]    acc_step;
    logic [nlip_pkg::SkipW-1:0]    skip_dec;
    nlip_pkg::push_t               emit;
    nlip_pkg::push_t               push_c;

    // line words from the head bytes as they stand after this byte
    always_comb
    begin
        num = acc_reg;
        if (acc_reg[nlip_pkg::WordW-1:1] == nlip_pkg::HostMark[nlip_pkg::WordW-1:1])
        begin
            num = '0;
        end
        emit = '0;
        if (head0_next == nlip_pkg::ChZ)
        begin
            emit.count = 2'd2;
            emit.word0 = nlip_pkg::ZoneMark;
            emit.word1 = num;
        end
        else if (head0_next == nlip_pkg::ChR)
        begin
            emit.count = 2'd2;
            emit.word0 = nlip_pkg::HostMark;
            emit.word1 = num;
        end
        else if (head0_next == nlip_pkg::ChH)
        begin
            if (head1_next != nlip_pkg::ChLowU && head2_next != nlip_pkg::ChLowL)
            begin
                emit.count = 2'd2;
                emit.word0 = nlip_pkg::HostMark;
                emit.word1 = num;
            end
            else
            begin
                emit.count = 2'd1;
                emit.word0 = num;
            end
        end
        else if (head0_next == nlip_pkg::ChComma || head0_next == nlip_pkg::ChP
                 || head0_next == nlip_pkg::ChD)
        begin
            emit.count = 2'd1;
            emit.word0 = num;
        end
    end

    // acc * 10 + byte - '0', wraps at 16 bits
    assign acc_step = (acc_reg << 3) + (acc_reg << 1)
                      + {{(nlip_pkg::WordW-nlip_pkg::ByteW){1'b0}}, byte_in}
                      - {{(nlip_pkg::WordW-nlip_pkg::ByteW){1'b0}}, nlip_pkg::ChZero};
    assign skip_dec  = skip_reg - 1'b1;
    assign in_number = (head0_reg == nlip_pkg::ChComma) ? (commas_reg == 2'd0)
                                                        : (commas_reg == 2'd1);

    always_comb
    begin
        phase_next  = phase_reg;
        head0_next  = head0_reg;
        head1_next  = head1_reg;
        head2_next  = head2_reg;
        chars_next  = chars_reg;
        commas_next = commas_reg;
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        push_c      = '0;
        case (phase_reg)
            nlip_pkg::PH_LINE:
            begin
                if (byte_in == nlip_pkg::ChNul || byte_in == nlip_pkg::ChEof)
                begin
                    push_c.count = 2'd1;
                    push_c.word0 = nlip_pkg::EndWord;
                    phase_next   = nlip_pkg::PH_HALT;
                end
                else if (byte_in == nlip_pkg::ChCr || byte_in == nlip_pkg::ChLf
                         || byte_in == nlip_pkg::ChEsc)
                begin
                    phase_next = phase_reg;
                end
                else if (byte_in == nlip_pkg::ChSemi)
                begin
                    phase_next = nlip_pkg::PH_COMMENT;
                end
                else
                begin
                    head0_next  = byte_in;
                    head1_next  = '0;
                    head2_next  = '0;
                    chars_next  = 2'd1;
                    commas_next = 2'd0;
                    acc_next    = '0;
                    phase_next  = nlip_pkg::PH_FIELDS;
                end
            end
            nlip_pkg::PH_COMMENT, nlip_pkg::PH_TAIL:
            begin
                if (byte_in == nlip_pkg::ChNul || byte_in == nlip_pkg::ChLf)
                begin
                    phase_next = nlip_pkg::PH_LINE;
                end
            end
            nlip_pkg::PH_FIELDS:
            begin
                case (chars_reg)
                    2'd0:    head0_next = byte_in;
                    2'd1:    head1_next = byte_in;
                    2'd2:    head2_next = byte_in;
                    default: head2_next = head2_reg;
                endcase
                if (chars_reg != 2'd3)
                begin
                    chars_next = chars_reg + 2'd1;
                end
                if (byte_in == nlip_pkg::ChComma)
                begin
                    if (commas_reg != 2'd0)
                    begin
                        // second comma closes the field part
                        commas_next = 2'd2;
                        push_c      = emit;
                        skip_next   = cfg_skip_reg;
                        phase_next  = (cfg_skip_reg == '0) ? nlip_pkg::PH_TAIL
                                                           : nlip_pkg::PH_SKIP;
                    end
                    else
                    begin
                        commas_next = 2'd1;
                    end
                end
                else if (in_number)
                begin
                    acc_next = acc_step;
                end
            end
            nlip_pkg::PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = nlip_pkg::PH_TAIL;
                end
            end
            nlip_pkg::PH_HALT:
            begin
                phase_next = nlip_pkg::PH_HALT;
            end
            default:
            begin
                phase_next = nlip_pkg::PH_HALT;
            end
        endcase
    end

    assign push = byte_fire ? push_c : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= nlip_pkg::PH_LINE;
            head0_reg    <= '0;
            head1_reg    <= '0;
            head2_reg    <= '0;
            chars_reg    <= '0;
            commas_reg   <= '0;
            acc_reg      <= '0;
            skip_reg     <= '0;
            cfg_skip_reg <= nlip_pkg::SkipReset;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_skip_reg <= cfg_wr_data;
            end
            if (byte_fire)
            begin
                phase_reg  <= phase_next;
                head0_reg  <= head0_next;
                head1_reg  <= head1_next;
                head2_reg  <= head2_next;
                chars_reg  <= chars_next;
                commas_reg <= commas_next;
                acc_reg    <= acc_next;
                skip_reg   <= skip_next;
            end
        end
    end

endmodule

// ===== hw/rtl/nlip_out_queue.sv =====
module nlip_out_queue
#(
    parameter int unsigned DEPTH = nlip_pkg::QDepth
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nlip_pkg::push_t               push,
    output logic                          room2,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nlip_pkg::WordW-1:0]    out_word
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic [nlip_pkg::WordW-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [PtrW-1:0]            wr_ptr_1;
    logic [CntW-1:0]            count_reg, count_next;
    logic                       pop;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign room2     = (count_reg <= CntW'(DEPTH - 2));
    assign wr_ptr_1  = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push.count) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.word0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.word1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/node_list_index_parser.sv =====
// node list index parser
//
// input channel: in_valid / in_stall / in_byte, one text byte per transfer.
// a transfer happens on a rising edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall / index_word, one 16-bit index word
// per transfer (zone marker, host marker, node number, or 0 at list end).
// config: cfg_wr_en / cfg_wr_data writes the skip count used after the
// number field of each line; write it only while the block is idle.
//
// every byte is parsed on the edge it is accepted and its words (up to two)
// land in a small output queue; with the queue empty, the first word is
// visible in the cycle after the byte that closes a line. a byte is taken
// every cycle while the queue has room for two words (one byte per cycle
// sustained); at the default depth only output stall can take that room.
// when the receiver stalls, the queue fills and in_stall rises; nothing is
// dropped and the head word holds steady.
// reset (rst_n low, async) empties the queue, returns the parser to line
// start and loads the skip count with 35. after the end word the parser
// ignores all input until the next reset.
module node_list_index_parser
#(
    parameter int unsigned QUEUE_DEPTH = nlip_pkg::QDepth
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [nlip_pkg::SkipW-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nlip_pkg::ByteW-1:0]    in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nlip_pkg::WordW-1:0]    index_word
);

    logic            room2;
    logic            byte_fire;
    nlip_pkg::push_t push;

    // hold input off unless the queue can absorb a full two-word line
    assign in_stall  = !room2;
    assign byte_fire = in_valid && !in_stall;

    // byte-level parse state, skip count register and word generation
    nlip_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_fire   (byte_fire),
        .byte_in     (in_byte),
        .push        (push)
    );

    // result queue separating parser from the output handshake
    nlip_out_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (index_word)
    );

endmodule
